FILE: design/sqv_pkg.sv
package sqv_pkg;

   localparam int unsigned MID_DEPTH_DEF = 2;
   localparam int unsigned OUT_DEPTH_DEF = 2;

   localparam logic [16:0] QUARTER = 17'd16384;
   localparam logic [31:0] C1 = 32'd1686629713;
   localparam logic [31:0] C3 = 32'd693598668;
   localparam logic [31:0] C5 = 32'd85569306;
   localparam logic [31:0] C7 = 32'd5026995;
   localparam logic [31:0] C9 = 32'd172272;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef enum logic [1:0] {
      CORNER_TL = 2'd0,
      CORNER_TR = 2'd1,
      CORNER_BL = 2'd2,
      CORNER_BR = 2'd3
   } corner_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        size_w;
      logic [15:0]        size_h;
      logic [15:0]        scale;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic [15:0]        tex_du;
      logic [15:0]        tex_dv;
      logic [31:0]        color;
      logic               last_object;
   } item_type;

   typedef struct packed {
      item_type           item;
      logic signed [15:0] sin;
      logic signed [15:0] cos;
   } mid_type;

   typedef struct packed {
      corner_type         corner;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic [16:0]        out_u;
      logic [16:0]        out_v;
      logic [31:0]        out_color;
      logic               last_corner;
      logic               frame_end;
   } out_type;

   // horner coefficient subtracted in front stage k (3..5)
   function automatic logic [31:0] horner_coef(input int k);
      logic [31:0] c;
      c = C1;
      if (k == 3) c = C5;
      else if (k == 4) c = C3;
      return c;
   endfunction

endpackage

FILE: design/sqv_fifo.sv
module sqv_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] din,
   input  logic             rd_en,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      else if (!wr_en && rd_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_ptr_ff] <= din;
   end

   assign dout  = mem[rd_ptr_ff];
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en && full |-> rd_en) else $error("write into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty) else $error("read from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      wr_en && !rd_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count out of step");
`endif

endmodule

FILE: design/sqv_front.sv
module sqv_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  sqv_pkg::item_type  req_item,
   input  logic [15:0]        req_angle,
   output logic               mq_push,
   output sqv_pkg::mid_type   mq_data,
   input  logic               mq_full
);
   import sqv_pkg::*;

   logic                adv;
   logic [7:1]          valid_ff, valid_in;
   item_type            item_ff [1:7];
   quad_type            quad_ff [1:6];
   logic [14:0]         t_ff  [1:5][0:1];
   logic [30:0]         t2_ff [1:4][0:1];
   logic [31:0]         p_ff  [2:6][0:1];
   logic signed [15:0]  sin_ff, cos_ff, sin_in, cos_in;
   logic [14:0]         t_in  [0:1];
   logic [30:0]         t2_in [0:1];
   logic [31:0]         p_in  [2:6][0:1];
   logic [15:0]         mag   [0:1];

   assign adv      = !(valid_ff[7] && mq_full);
   assign full     = !adv;
   assign valid_in = {valid_ff[6:1], push};
   assign mq_push  = valid_ff[7] && adv;
   assign mq_data  = '{item: item_ff[7], sin: sin_ff, cos: cos_ff};

   // lane 0 evaluates the phase, lane 1 the complementary phase
   always_comb begin
      logic [29:0] sq;
      logic [63:0] prod;
      logic [46:0] fin;
      logic [32:0] rnd;
      t_in[0] = {1'b0, req_angle[13:0]};
      t_in[1] = 15'(QUARTER - {3'd0, req_angle[13:0]});
      for (int l = 0; l < 2; l++) begin
         sq          = {15'd0, t_in[l]} * {15'd0, t_in[l]};
         t2_in[l]    = {sq[28:0], 2'b00};
         prod        = {33'd0, t2_ff[1][l]} * {32'd0, C9};
         p_in[2][l]  = C7 - prod[61:30];
         for (int k = 3; k <= 5; k++) begin
            prod       = {33'd0, t2_ff[k-1][l]} * {32'd0, p_ff[k-1][l]};
            p_in[k][l] = horner_coef(k) - prod[61:30];
         end
         fin        = {17'd0, t_ff[5][l]} * {15'd0, p_ff[5][l]};
         p_in[6][l] = fin[45:14];
         rnd        = {1'b0, p_ff[6][l]} + 33'd32768;
         mag[l]     = (rnd[32:16] > QUARTER) ? 16'(QUARTER) : rnd[31:16];
      end
   end

   always_comb begin
      sin_in = $signed(mag[0]);
      cos_in = $signed(mag[1]);
      unique case (quad_ff[6])
         QUAD_0: begin
            sin_in = $signed(mag[0]);
            cos_in = $signed(mag[1]);
         end
         QUAD_1: begin
            sin_in = $signed(mag[1]);
            cos_in = -$signed(mag[0]);
         end
         QUAD_2: begin
            sin_in = -$signed(mag[0]);
            cos_in = -$signed(mag[1]);
         end
         QUAD_3: begin
            sin_in = -$signed(mag[1]);
            cos_in = $signed(mag[0]);
         end
         default: begin
            sin_in = $signed(mag[0]);
            cos_in = $signed(mag[1]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[1] <= req_item;
         quad_ff[1] <= quad_type'(req_angle[15:14]);
         for (int k = 2; k <= 7; k++) item_ff[k] <= item_ff[k-1];
         for (int k = 2; k <= 6; k++) quad_ff[k] <= quad_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            t_ff[1][l]  <= t_in[l];
            t2_ff[1][l] <= t2_in[l];
            for (int k = 2; k <= 5; k++) t_ff[k][l] <= t_ff[k-1][l];
            for (int k = 2; k <= 4; k++) t2_ff[k][l] <= t2_ff[k-1][l];
            for (int k = 2; k <= 6; k++) p_ff[k][l] <= p_in[k][l];
         end
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

endmodule

FILE: design/sqv_back.sv
module sqv_back #(
   parameter int unsigned OUT_DEPTH = sqv_pkg::OUT_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              mq_empty,
   input  sqv_pkg::mid_type  mq_data,
   output logic              mq_pop,
   input  logic              pop,
   output logic              empty,
   output sqv_pkg::out_type  rsp
);
   import sqv_pkg::*;

   corner_type          corner_ff, corner_in;
   logic                v1_ff, v2_ff;
   logic                b_adv, take, o_full, o_ok, o_push;
   logic signed [34:0]  rx_ff, ry_ff, rx_in, ry_in;
   logic signed [51:0]  mx_ff, my_ff;
   logic [15:0]         scale_ff;
   out_type             meta1_ff, meta1_in, meta2_ff, res;

   assign o_ok   = !o_full || (pop && !empty);
   assign b_adv  = !(v2_ff && !o_ok);
   assign take   = b_adv && !mq_empty;
   assign mq_pop = take && (corner_ff == CORNER_BR);
   assign o_push = v2_ff && o_ok;
   assign corner_in = corner_type'(corner_ff + 2'd1);

   always_comb begin
      logic signed [16:0] dx, dy, wp, hp;
      logic signed [34:0] px, py;
      wp = $signed({1'b0, mq_data.item.size_w});
      hp = $signed({1'b0, mq_data.item.size_h});
      dx = corner_ff[0] ? wp : -wp;
      dy = corner_ff[1] ? hp : -hp;
      px = 35'(mq_data.item.pos_x) <<< 15;
      py = 35'(mq_data.item.pos_y) <<< 15;
      rx_in = 35'(dx * mq_data.cos) - 35'(dy * mq_data.sin) + px;
      ry_in = 35'(dx * mq_data.sin) + 35'(dy * mq_data.cos) + py;
      meta1_in             = '0;
      meta1_in.corner      = corner_ff;
      meta1_in.out_u       = {1'b0, mq_data.item.tex_u}
                           + (corner_ff[0] ? {1'b0, mq_data.item.tex_du} : 17'd0);
      meta1_in.out_v       = {1'b0, mq_data.item.tex_v}
                           + (corner_ff[1] ? {1'b0, mq_data.item.tex_dv} : 17'd0);
      meta1_in.out_color   = mq_data.item.color;
      meta1_in.last_corner = (corner_ff == CORNER_BR);
      meta1_in.frame_end   = (corner_ff == CORNER_BR) && mq_data.item.last_object;
   end

   // round half up from q.27 to q.12, then clamp to 32 bits
   function automatic logic signed [31:0] to_q12(input logic signed [51:0] v);
      logic signed [51:0] s;
      logic signed [36:0] r;
      s = v + 52'sd16384;
      r = 37'(s >>> 15);
      if (r > 37'sd2147483647) return 32'sh7FFFFFFF;
      if (r < -37'sd2147483648) return 32'sh80000000;
      return r[31:0];
   endfunction

   always_comb begin
      res        = meta2_ff;
      res.vert_x = to_q12(mx_ff);
      res.vert_y = to_q12(my_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= CORNER_TL;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
      end else if (b_adv) begin
         if (take) corner_ff <= corner_in;
         v1_ff <= take;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         scale_ff <= mq_data.item.scale;
         meta1_ff <= meta1_in;
         mx_ff    <= 52'(rx_ff * $signed({1'b0, scale_ff}));
         my_ff    <= 52'(ry_ff * $signed({1'b0, scale_ff}));
         meta2_ff <= meta1_ff;
      end
   end

   sqv_fifo #(
      .WIDTH ($bits(out_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .wr_en (o_push),
      .din   (res),
      .rd_en (pop && !empty),
      .dout  (rsp),
      .full  (o_full),
      .empty (empty)
   );

endmodule

FILE: design/sprite_quad_vertex_setup.sv
// Sprite quad vertex setup: each sprite pushed in comes out as four vertex
// transfers (top-left, top-right, bottom-left, bottom-right), one vertex per
// cycle unless the middle queue is empty or the result queue is full and not
// popped. A seven-stage front pipeline evaluates sine and cosine by
// polynomial, one multiply per lane in each stage but the last, and hands
// the sprite to a short queue; the back end walks the corners, rotates,
// scales, rounds and saturates in two stages before the result queue.
// Either side may stall without losing items.
module sprite_quad_vertex_setup #(
   parameter int unsigned MID_DEPTH = sqv_pkg::MID_DEPTH_DEF,
   parameter int unsigned OUT_DEPTH = sqv_pkg::OUT_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]        req_size_w,
   input  logic [15:0]        req_size_h,
   input  logic [15:0]        req_angle,
   input  logic [15:0]        req_scale,
   input  logic [15:0]        req_tex_u,
   input  logic [15:0]        req_tex_v,
   input  logic [15:0]        req_tex_du,
   input  logic [15:0]        req_tex_dv,
   input  logic [31:0]        req_color,
   input  logic               req_last_object,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_corner,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic [16:0]        rsp_out_u,
   output logic [16:0]        rsp_out_v,
   output logic [31:0]        rsp_out_color,
   output logic               rsp_last_corner,
   output logic               rsp_frame_end
);
   import sqv_pkg::*;

   item_type item;
   mid_type  mq_in, mq_out;
   out_type  rsp;
   logic     mq_push, mq_pop, mq_full, mq_empty;

   assign item = '{pos_x: req_pos_x, pos_y: req_pos_y, size_w: req_size_w,
                   size_h: req_size_h, scale: req_scale, tex_u: req_tex_u,
                   tex_v: req_tex_v, tex_du: req_tex_du, tex_dv: req_tex_dv,
                   color: req_color, last_object: req_last_object};

   sqv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (item),
      .req_angle (req_angle),
      .mq_push   (mq_push),
      .mq_data   (mq_in),
      .mq_full   (mq_full)
   );

   sqv_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .wr_en (mq_push),
      .din   (mq_in),
      .rd_en (mq_pop),
      .dout  (mq_out),
      .full  (mq_full),
      .empty (mq_empty)
   );

   sqv_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .mq_empty (mq_empty),
      .mq_data  (mq_out),
      .mq_pop   (mq_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp      (rsp)
   );

   assign rsp_corner      = rsp.corner;
   assign rsp_vert_x      = rsp.vert_x;
   assign rsp_vert_y      = rsp.vert_y;
   assign rsp_out_u       = rsp.out_u;
   assign rsp_out_v       = rsp.out_v;
   assign rsp_out_color   = rsp.out_color;
   assign rsp_last_corner = rsp.last_corner;
   assign rsp_frame_end   = rsp.frame_end;

endmodule
